>>> sv/cps_pkg.sv
package cps_pkg;

  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned FACTOR_BITS = 32;

  // |coordinate difference| fits DIFF_W bits, squares and dot terms PROD_W,
  // their sums SQ_W
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned SQ_W   = PROD_W + 1;
  // quotient bits per divider: enough for the factor before saturation and
  // for an interpolation offset
  localparam int unsigned QUO_W  = (DIFF_W > FACTOR_BITS + 1) ? DIFF_W : FACTOR_BITS + 1;
  localparam int unsigned NUM_W  = SQ_W + QUO_W;

  localparam logic [1:0] WHERE_INTERIOR = 2'd0;
  localparam logic [1:0] WHERE_START    = 2'd1;
  localparam logic [1:0] WHERE_END      = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } cps_in_t;

  typedef struct packed {
    logic signed [FACTOR_BITS-1:0] factor_raw;
    logic                          factor_saturated;
    logic [FRAC_BITS:0]            fraction_clamped;
    logic signed [COORD_BITS-1:0]  closest_x;
    logic signed [COORD_BITS-1:0]  closest_y;
    logic [1:0]                    where_found;
    logic                          degenerate;
  } cps_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
  } cps_pts_t;

  typedef struct packed {
    cps_pts_t pts;
    logic     dx_neg;
    logic     dy_neg;
    logic     dot_neg;
    logic     dot_zero;
    logic     degen;
    logic     interior;
    logic     end_near;
    logic     ovf;
    logic     frac_one;
  } cps_side_t;

  typedef struct packed {
    cps_side_t        side;
    logic [NUM_W-1:0] num_f;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [SQ_W-1:0]  den;
  } cps_front_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic [SQ_W-1:0]  rem;
    logic [SQ_W-1:0]  den;
  } cps_quo_t;

endpackage

>>> sv/closest_point_on_segment_top.sv
// Closest point on a line segment.
// Input channel: in_valid_i / in_stall_o with in_i carrying segment start,
// segment end and query point. Output channel: out_valid_o / out_stall_i
// with out_o carrying the Q16.16 factor, its saturation flag, the factor
// clamped to 0..1, the closest point, where it was found and a flag for a
// zero-length segment.
// The path from input transfer to output valid runs through six front
// stages (differences, products, sums, sign, partial products, numerators),
// a 33-stage divider with one quotient bit per stage (three lanes side by
// side: factor, x and y offsets) and the output register.
// Throughput is one item per cycle while out_stall_i does not hold the pipeline.
// Reset clears all valid bits; the pipeline is empty and ready at once.
// While a result sits in the output register and out_stall_i is high the
// whole pipeline holds and in_stall_o is raised; nothing is dropped.
module closest_point_on_segment_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cps_pkg::cps_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cps_pkg::cps_out_t out_o
);
  import cps_pkg::*;

  logic       adv;
  logic       front_valid, tail_valid;
  cps_front_t front;
  cps_side_t  tail_side;
  cps_quo_t   fac, qx, qy;
  cps_out_t   res;
  logic       out_valid_q;
  cps_out_t   out_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  cps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .in_i    (in_i),
    .valid_o (front_valid),
    .front_o (front)
  );

  cps_div #(.QW(QUO_W), .DW(SQ_W)) u_div_f (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (front.num_f),
    .den_i (front.den),
    .quo_o (fac.quo),
    .rem_o (fac.rem),
    .den_o (fac.den)
  );

  cps_div #(.QW(QUO_W), .DW(SQ_W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (front.num_x),
    .den_i (front.den),
    .quo_o (qx.quo),
    .rem_o (qx.rem),
    .den_o (qx.den)
  );

  cps_div #(.QW(QUO_W), .DW(SQ_W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (front.num_y),
    .den_i (front.den),
    .quo_o (qy.quo),
    .rem_o (qy.rem),
    .den_o (qy.den)
  );

  cps_delay #(.DEPTH(QUO_W)) u_delay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (front_valid),
    .side_i  (front.side),
    .valid_o (tail_valid),
    .side_o  (tail_side)
  );

  cps_back u_back (
    .side_i (tail_side),
    .fac_i  (fac),
    .qx_i   (qx),
    .qy_i   (qy),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_degenerate_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.degenerate) |->
      (out_o.where_found == WHERE_START && out_o.factor_raw == '0 &&
       !out_o.factor_saturated && out_o.fraction_clamped == '0))
    else $error("zero-length segment gave a wrong result");

  a_sat_not_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.factor_saturated) |-> (out_o.where_found != WHERE_INTERIOR))
    else $error("saturated factor reported as interior projection");

endmodule

>>> sv/cps_front.sv
module cps_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cps_pkg::cps_in_t   in_i,
  output logic               valid_o,
  output cps_pkg::cps_front_t front_o
);
  import cps_pkg::*;

  function automatic logic [DIFF_W-1:0] mag_f(logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] u;
    u = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return u;
  endfunction

  logic [5:0] vld_q;

  // stage A: differences
  logic signed [DIFF_W-1:0] sx_e, sy_e, ex_e, ey_e, px_e, py_e;
  cps_pts_t a_pts_q;
  logic signed [DIFF_W-1:0] a_dx_q, a_dy_q, a_ax_q, a_ay_q, a_bx_q, a_by_q;
  // stage B: magnitudes and products
  cps_pts_t b_pts_q;
  logic [DIFF_W-1:0] b_mdx_q, b_mdy_q;
  logic b_dxn_q, b_dyn_q, b_sgx_q, b_sgy_q;
  logic [PROD_W-1:0] b_lxx_q, b_lyy_q, b_pdx_q, b_pdy_q;
  logic [PROD_W-1:0] b_ax2_q, b_ay2_q, b_bx2_q, b_by2_q;
  // stage C: sums
  cps_pts_t c_pts_q;
  logic [DIFF_W-1:0] c_mdx_q, c_mdy_q;
  logic c_dxn_q, c_dyn_q;
  logic [SQ_W-1:0] c_len2_q, c_d0_q, c_d1_q;
  logic signed [SQ_W:0] c_dot_q;
  logic signed [SQ_W:0] dot_x, dot_y, dot_abs;
  // stage D: sign and magnitude
  cps_pts_t d_pts_q;
  logic [DIFF_W-1:0] d_mdx_q, d_mdy_q;
  logic d_dxn_q, d_dyn_q, d_neg_q, d_degen_q, d_end_q;
  logic [SQ_W-1:0] d_len2_q, d_mag_q;
  // stage E: flags and partial products
  cps_pts_t e_pts_q;
  logic e_dxn_q, e_dyn_q, e_neg_q, e_degen_q, e_end_q, e_zero_q, e_one_q, e_ovf_q;
  logic [SQ_W-1:0] e_len2_q, e_mag_q;
  logic [PROD_W-1:0] e_pxl_q, e_pyl_q;
  logic [SQ_W-1:0]   e_pxh_q, e_pyh_q;
  // stage F: numerators
  cps_front_t f_q, f_d;

  assign sx_e = $signed({in_i.seg_start_x[COORD_BITS-1], in_i.seg_start_x});
  assign sy_e = $signed({in_i.seg_start_y[COORD_BITS-1], in_i.seg_start_y});
  assign ex_e = $signed({in_i.seg_end_x[COORD_BITS-1], in_i.seg_end_x});
  assign ey_e = $signed({in_i.seg_end_y[COORD_BITS-1], in_i.seg_end_y});
  assign px_e = $signed({in_i.point_x[COORD_BITS-1], in_i.point_x});
  assign py_e = $signed({in_i.point_y[COORD_BITS-1], in_i.point_y});

  assign dot_x   = b_sgx_q ? -$signed({2'b00, b_pdx_q}) : $signed({2'b00, b_pdx_q});
  assign dot_y   = b_sgy_q ? -$signed({2'b00, b_pdy_q}) : $signed({2'b00, b_pdy_q});
  assign dot_abs = c_dot_q[SQ_W] ? -c_dot_q : c_dot_q;

  always_comb begin
    f_d.side.pts      = e_pts_q;
    f_d.side.dx_neg   = e_dxn_q;
    f_d.side.dy_neg   = e_dyn_q;
    f_d.side.dot_neg  = e_neg_q;
    f_d.side.dot_zero = e_zero_q;
    f_d.side.degen    = e_degen_q;
    f_d.side.interior = !e_neg_q && !e_zero_q && !e_one_q;
    f_d.side.end_near = e_end_q;
    f_d.side.ovf      = e_ovf_q;
    f_d.side.frac_one = e_one_q;
    f_d.num_f         = NUM_W'(e_mag_q) << FRAC_BITS;
    f_d.num_x         = (NUM_W'(e_pxh_q) << DIFF_W) + NUM_W'(e_pxl_q);
    f_d.num_y         = (NUM_W'(e_pyh_q) << DIFF_W) + NUM_W'(e_pyl_q);
    f_d.den           = e_len2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pts_q <= '{sx: in_i.seg_start_x, sy: in_i.seg_start_y,
                   ex: in_i.seg_end_x, ey: in_i.seg_end_y};
      a_dx_q  <= ex_e - sx_e;
      a_dy_q  <= ey_e - sy_e;
      a_ax_q  <= px_e - sx_e;
      a_ay_q  <= py_e - sy_e;
      a_bx_q  <= px_e - ex_e;
      a_by_q  <= py_e - ey_e;

      b_pts_q <= a_pts_q;
      b_mdx_q <= mag_f(a_dx_q);
      b_mdy_q <= mag_f(a_dy_q);
      b_dxn_q <= a_dx_q[DIFF_W-1];
      b_dyn_q <= a_dy_q[DIFF_W-1];
      b_sgx_q <= a_ax_q[DIFF_W-1] ^ a_dx_q[DIFF_W-1];
      b_sgy_q <= a_ay_q[DIFF_W-1] ^ a_dy_q[DIFF_W-1];
      b_lxx_q <= PROD_W'(mag_f(a_dx_q)) * PROD_W'(mag_f(a_dx_q));
      b_lyy_q <= PROD_W'(mag_f(a_dy_q)) * PROD_W'(mag_f(a_dy_q));
      b_pdx_q <= PROD_W'(mag_f(a_ax_q)) * PROD_W'(mag_f(a_dx_q));
      b_pdy_q <= PROD_W'(mag_f(a_ay_q)) * PROD_W'(mag_f(a_dy_q));
      b_ax2_q <= PROD_W'(mag_f(a_ax_q)) * PROD_W'(mag_f(a_ax_q));
      b_ay2_q <= PROD_W'(mag_f(a_ay_q)) * PROD_W'(mag_f(a_ay_q));
      b_bx2_q <= PROD_W'(mag_f(a_bx_q)) * PROD_W'(mag_f(a_bx_q));
      b_by2_q <= PROD_W'(mag_f(a_by_q)) * PROD_W'(mag_f(a_by_q));

      c_pts_q  <= b_pts_q;
      c_mdx_q  <= b_mdx_q;
      c_mdy_q  <= b_mdy_q;
      c_dxn_q  <= b_dxn_q;
      c_dyn_q  <= b_dyn_q;
      c_len2_q <= SQ_W'(b_lxx_q) + SQ_W'(b_lyy_q);
      c_d0_q   <= SQ_W'(b_ax2_q) + SQ_W'(b_ay2_q);
      c_d1_q   <= SQ_W'(b_bx2_q) + SQ_W'(b_by2_q);
      c_dot_q  <= dot_x + dot_y;

      d_pts_q   <= c_pts_q;
      d_mdx_q   <= c_mdx_q;
      d_mdy_q   <= c_mdy_q;
      d_dxn_q   <= c_dxn_q;
      d_dyn_q   <= c_dyn_q;
      d_len2_q  <= c_len2_q;
      d_mag_q   <= dot_abs[SQ_W-1:0];
      d_neg_q   <= c_dot_q[SQ_W];
      d_degen_q <= (c_len2_q == '0);
      d_end_q   <= !(c_d0_q < c_d1_q);  // ties go to the end point

      e_pts_q   <= d_pts_q;
      e_dxn_q   <= d_dxn_q;
      e_dyn_q   <= d_dyn_q;
      e_neg_q   <= d_neg_q;
      e_degen_q <= d_degen_q;
      e_end_q   <= d_end_q;
      e_len2_q  <= d_len2_q;
      e_mag_q   <= d_mag_q;
      e_zero_q  <= (d_mag_q == '0);
      e_one_q   <= (d_mag_q >= d_len2_q);
      // quotient would not fit the divider: saturates whatever the sign
      e_ovf_q   <= (NUM_W'(d_mag_q) << FRAC_BITS) >= (NUM_W'(d_len2_q) << QUO_W);
      e_pxl_q   <= PROD_W'(d_mag_q[DIFF_W-1:0]) * PROD_W'(d_mdx_q);
      e_pyl_q   <= PROD_W'(d_mag_q[DIFF_W-1:0]) * PROD_W'(d_mdy_q);
      e_pxh_q   <= SQ_W'(d_mag_q[SQ_W-1:DIFF_W]) * SQ_W'(d_mdx_q);
      e_pyh_q   <= SQ_W'(d_mag_q[SQ_W-1:DIFF_W]) * SQ_W'(d_mdy_q);

      f_q <= f_d;
    end
  end

  assign valid_o = vld_q[5];
  assign front_o = f_q;

endmodule

>>> sv/cps_div.sv
module cps_div #(
  parameter int unsigned QW = 33,
  parameter int unsigned DW = 51
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QW-1:0]    quo_o,
  output logic [DW-1:0]    rem_o,
  output logic [DW-1:0]    den_o
);

  // restoring division, one quotient bit per stage; num_i >> QW < den_i
  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] low_q [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] r_in, d_in;
    logic [QW-1:0] q_in, lo_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in  = num_i[DW+QW-1:QW];
      assign lo_in = num_i[QW-1:0];
      assign q_in  = '0;
      assign d_in  = den_i;
    end else begin : g_next
      assign r_in  = rem_q[k-1];
      assign lo_in = low_q[k-1];
      assign q_in  = quo_q[k-1];
      assign d_in  = den_q[k-1];
    end

    assign t  = {r_in, lo_in[QW-1-k]};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
        den_q[k] <= d_in;
        quo_q[k] <= {q_in[QW-2:0], ge};
      end
    end

    if (k < QW - 1) begin : g_low
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          low_q[k] <= lo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];
  assign rem_o = rem_q[QW-1];
  assign den_o = den_q[QW-1];

endmodule

>>> sv/cps_delay.sv
module cps_delay #(
  parameter int unsigned DEPTH = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cps_pkg::cps_side_t side_i,
  output logic               valid_o,
  output cps_pkg::cps_side_t side_o
);
  import cps_pkg::*;

  logic [DEPTH-1:0] vld_q;
  cps_side_t        side_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= DEPTH'({vld_q, valid_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[DEPTH-1];
  assign side_o  = side_q[DEPTH-1];

endmodule

>>> sv/cps_back.sv
module cps_back (
  input  cps_pkg::cps_side_t side_i,
  input  cps_pkg::cps_quo_t  fac_i,
  input  cps_pkg::cps_quo_t  qx_i,
  input  cps_pkg::cps_quo_t  qy_i,
  output cps_pkg::cps_out_t  res_o
);
  import cps_pkg::*;

  localparam logic [FACTOR_BITS-1:0] FACTOR_MAX = {1'b0, {(FACTOR_BITS-1){1'b1}}};
  localparam logic [FACTOR_BITS-1:0] FACTOR_MIN = {1'b1, {(FACTOR_BITS-1){1'b0}}};
  localparam logic [FRAC_BITS:0]     FRAC_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

  // round to nearest, halves up
  function automatic logic [QUO_W:0] round_f(cps_quo_t q);
    logic up;
    up = ({q.rem, 1'b0} >= {1'b0, q.den});
    return {1'b0, q.quo} + (QUO_W+1)'(up);
  endfunction

  logic [QUO_W:0] qf, qx, qy, qf_neg;
  logic [COORD_BITS-1:0] offx, offy;

  assign qf     = round_f(fac_i);
  assign qx     = round_f(qx_i);
  assign qy     = round_f(qy_i);
  assign qf_neg = -qf;
  assign offx   = qx[COORD_BITS-1:0];
  assign offy   = qy[COORD_BITS-1:0];

  always_comb begin
    res_o.factor_raw       = '0;
    res_o.factor_saturated = 1'b0;
    res_o.fraction_clamped = '0;
    res_o.closest_x        = side_i.pts.sx;
    res_o.closest_y        = side_i.pts.sy;
    res_o.where_found      = WHERE_START;
    res_o.degenerate       = side_i.degen;
    if (!side_i.degen) begin
      if (!side_i.dot_neg) begin
        if (side_i.ovf || qf > (QUO_W+1)'(FACTOR_MAX)) begin
          res_o.factor_raw       = FACTOR_MAX;
          res_o.factor_saturated = 1'b1;
        end else begin
          res_o.factor_raw = qf[FACTOR_BITS-1:0];
        end
      end else begin
        if (side_i.ovf || qf > (QUO_W+1)'(FACTOR_MIN)) begin
          res_o.factor_raw       = FACTOR_MIN;
          res_o.factor_saturated = 1'b1;
        end else begin
          res_o.factor_raw = qf_neg[FACTOR_BITS-1:0];
        end
      end

      if (side_i.dot_neg || side_i.dot_zero) begin
        res_o.fraction_clamped = '0;
      end else if (side_i.frac_one) begin
        res_o.fraction_clamped = FRAC_ONE;
      end else begin
        res_o.fraction_clamped = qf[FRAC_BITS:0];
      end

      if (side_i.interior) begin
        res_o.where_found = WHERE_INTERIOR;
        res_o.closest_x   = side_i.dx_neg ? side_i.pts.sx - offx : side_i.pts.sx + offx;
        res_o.closest_y   = side_i.dy_neg ? side_i.pts.sy - offy : side_i.pts.sy + offy;
      end else if (side_i.end_near) begin
        res_o.where_found = WHERE_END;
        res_o.closest_x   = side_i.pts.ex;
        res_o.closest_y   = side_i.pts.ey;
      end
    end
  end

endmodule

>>> dv/tb_top.sv
module tb_top;
  import cps_pkg::*;

  localparam int LATENCY    = 40;
  localparam int IDLE_PCT   = 32;
  localparam int STALL_LIM  = 4000;
  localparam int N_RANDOM   = 1330;
  localparam longint CMAX   = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint CMIN   = -(64'sd1 <<< (COORD_BITS - 1));

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  cps_in_t  in_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  cps_out_t out_o;

  cps_out_t expected_q[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_interior = 0;
  int       n_endpoint = 0;
  int       n_degen = 0;
  int       n_sat = 0;
  int       quiet_cycles = 0;
  bit       busy_hours = 1'b1;   // idling and stalling enabled

  closest_point_on_segment_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // round to nearest, halves up, on magnitudes
  function automatic logic [127:0] div_nearest(logic [127:0] n, logic [127:0] d);
    logic [127:0] q;
    logic [127:0] r;
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    return q;
  endfunction

  function automatic cps_out_t predict_closest(cps_in_t a);
    longint       sx, sy, ex, ey, px, py, dx, dy, dot, ax, ay, bx, by, off;
    logic [127:0] len2, dmag, q, d0, d1;
    cps_out_t     o;
    sx = a.seg_start_x; sy = a.seg_start_y;
    ex = a.seg_end_x;   ey = a.seg_end_y;
    px = a.point_x;     py = a.point_y;
    dx = ex - sx;
    dy = ey - sy;
    dot = (px - sx) * dx + (py - sy) * dy;
    len2 = 128'(dx * dx + dy * dy);
    o = '0;
    o.closest_x = a.seg_start_x;
    o.closest_y = a.seg_start_y;
    o.where_found = WHERE_START;
    if (len2 == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    dmag = 128'(dot < 0 ? -dot : dot);
    q = div_nearest(dmag << FRAC_BITS, len2);
    if (dot >= 0) begin
      if (q > 128'h7fff_ffff) begin
        o.factor_saturated = 1'b1;
        o.factor_raw = 32'h7fff_ffff;
      end else begin
        o.factor_raw = q[31:0];
      end
    end else if (q > 128'h8000_0000) begin
      o.factor_saturated = 1'b1;
      o.factor_raw = 32'h8000_0000;
    end else begin
      o.factor_raw = -q[31:0];
    end
    if (dot <= 0) o.fraction_clamped = '0;
    else if (dmag >= len2) o.fraction_clamped = 17'(1 << FRAC_BITS);
    else o.fraction_clamped = q[FRAC_BITS:0];
    if (dot > 0 && dmag < len2) begin
      o.where_found = WHERE_INTERIOR;
      off = longint'(div_nearest(dmag * 128'(dx < 0 ? -dx : dx), len2));
      o.closest_x = COORD_BITS'(dx < 0 ? sx - off : sx + off);
      off = longint'(div_nearest(dmag * 128'(dy < 0 ? -dy : dy), len2));
      o.closest_y = COORD_BITS'(dy < 0 ? sy - off : sy + off);
    end else begin
      ax = px - sx; ay = py - sy; bx = px - ex; by = py - ey;
      d0 = 128'(ax * ax + ay * ay);
      d1 = 128'(bx * bx + by * by);
      if (d0 >= d1) begin
        o.where_found = WHERE_END;
        o.closest_x = a.seg_end_x;
        o.closest_y = a.seg_end_y;
      end
    end
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", n_checked, field, got, want);
    n_errors++;
  endtask

  task automatic send_query(longint sx, longint sy, longint ex, longint ey,
                            longint px, longint py);
    cps_in_t it;
    cps_out_t p;
    it.seg_start_x = COORD_BITS'(sx); it.seg_start_y = COORD_BITS'(sy);
    it.seg_end_x   = COORD_BITS'(ex); it.seg_end_y   = COORD_BITS'(ey);
    it.point_x     = COORD_BITS'(px); it.point_y     = COORD_BITS'(py);
    while (busy_hours && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    p = predict_closest(it);
    expected_q.push_back(p);
    n_sent++;
    if (p.degenerate) n_degen++;
    else if (p.where_found == WHERE_INTERIOR) n_interior++;
    else n_endpoint++;
    if (p.factor_saturated) n_sat++;
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    cps_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result transfer: %h", out_o);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_o.factor_raw !== want.factor_raw)
          report("factor_raw", out_o.factor_raw, want.factor_raw);
        if (out_o.factor_saturated !== want.factor_saturated)
          report("factor_saturated", 32'(out_o.factor_saturated), 32'(want.factor_saturated));
        if (out_o.fraction_clamped !== want.fraction_clamped)
          report("fraction_clamped", 32'(out_o.fraction_clamped), 32'(want.fraction_clamped));
        if (out_o.closest_x !== want.closest_x)
          report("closest_x", 32'(out_o.closest_x), 32'(want.closest_x));
        if (out_o.closest_y !== want.closest_y)
          report("closest_y", 32'(out_o.closest_y), 32'(want.closest_y));
        if (out_o.where_found !== want.where_found)
          report("where_found", 32'(out_o.where_found), 32'(want.where_found));
        if (out_o.degenerate !== want.degenerate)
          report("degenerate", 32'(out_o.degenerate), 32'(want.degenerate));
      end
      n_checked++;
    end
    out_stall_i <= busy_hours && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIM) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint rand_coord();
    return longint'($signed(COORD_BITS'($urandom)));
  endfunction

  // near a base, kept on the grid
  function automatic longint jitter(longint base, int span);
    longint v;
    v = base + $urandom_range(2 * span) - span;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  task automatic test_degenerate();
    send_query(0, 0, 0, 0, 0, 0);
    send_query(5, -7, 5, -7, 100, 3);
    send_query(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX);
  endtask

  task automatic test_interior();
    send_query(0, 0, 10, 0, 3, 5);
    send_query(0, 0, 2, 2, 2, 0);          // exact half of the segment
    send_query(-3, 4, 4, -3, 0, 0);
    send_query(0, 0, 3, 0, 1, 1);          // factor one third, rounded
    send_query(0, 0, -7, 3, -2, 9);
    send_query(0, 0, 2, 2, 1, 0);          // offsets land on a half
  endtask

  task automatic test_endpoints();
    send_query(0, 0, 10, 0, 0, 5);         // dot zero, start
    send_query(0, 0, 10, 0, 10, -5);       // dot equals squared length, end
    send_query(0, 0, 10, 0, -20, 3);       // before start
    send_query(0, 0, 10, 0, 40, 3);        // beyond end
    send_query(2, 2, -4, 6, -9, 13);
  endtask

  task automatic test_extremes();
    send_query(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN);
    send_query(CMIN, CMIN, CMAX, CMAX, 0, 0);
    send_query(0, 0, 1, 0, CMAX, CMAX);    // factor overflows upwards
    send_query(0, 0, 1, 0, CMIN, CMIN);    // factor overflows downwards
    send_query(0, 0, 0, 1, 0, 32767);      // just fits
    send_query(0, 0, 0, 1, 0, 32768);
    send_query(0, 0, 0, 1, 0, -32768);     // most negative without saturation
    send_query(0, 0, 0, 1, 0, -32769);
    send_query(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN);
    send_query(-1, -1, -1, -1, -1, -1);
  endtask

  task automatic test_random();
    longint sx, sy, ex, ey, px, py;
    int     mode;
    for (int i = 0; i < N_RANDOM; i++) begin
      busy_hours = !(i >= 400 && i < 600);
      mode = $urandom_range(19);
      sx = rand_coord(); sy = rand_coord();
      ex = rand_coord(); ey = rand_coord();
      px = rand_coord(); py = rand_coord();
      if (mode < 6) begin
        // small cluster somewhere on the grid
        ex = jitter(sx, 300); ey = jitter(sy, 300);
        px = jitter(sx, 600); py = jitter(sy, 600);
      end else if (mode < 10) begin
        // point close to the segment body
        px = (sx + ex) / 2 + $urandom_range(64) - 32;
        py = (sy + ey) / 2 + $urandom_range(64) - 32;
      end else if (mode < 12) begin
        // short segment, far point: saturation
        ex = jitter(sx, 2); ey = jitter(sy, 2);
      end else if (mode == 12) begin
        ex = sx; ey = sy;
      end else if (mode == 13) begin
        // point on an endpoint
        if ($urandom_range(1)) begin px = sx; py = sy; end
        else begin px = ex; py = ey; end
      end
      send_query(sx, sy, ex, ey, px, py);
    end
    busy_hours = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_degenerate();
    test_interior();
    test_endpoints();
    test_extremes();
    test_random();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("%0d queries sent, %0d results checked", n_sent, n_checked);
    $display("interior %0d, endpoint %0d, zero-length %0d, saturated factor %0d",
             n_interior, n_endpoint, n_degen, n_sat);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cps_pkg.sv
sv/cps_front.sv
sv/cps_div.sv
sv/cps_delay.sv
sv/cps_back.sv
sv/closest_point_on_segment_top.sv
dv/tb_top.sv
